// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of the sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/isort_pkg.sv =====
// Types and constants shared by the insertion sorter modules.
package isort_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } cell_op_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        cell_op_t op;
        value_t   value;
    } cell_ctl_t;

    typedef struct packed {
        logic m_valid;
        logic m_last;
        logic m_overflow;
        logic take_bottom;
    } out_ctl_t;

endpackage

// ===== src/isort_cell.sv =====
// One cell of the sorting chain: holds a value and its valid bit.
module isort_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  isort_pkg::cell_ctl_t ctl,
    input  logic               lower_push,
    input  logic               lower_valid,
    input  isort_pkg::value_t  lower_value,
    input  logic               upper_valid,
    input  isort_pkg::value_t  upper_value,
    output logic               push,
    output logic               valid,
    output isort_pkg::value_t  value
);
    import isort_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    value_t value_reg;
    value_t value_next;

    // A cell gives way to the new value when it is empty or holds a larger value.
    assign push  = !valid_reg || (ctl.value < value_reg);
    assign valid = valid_reg;
    assign value = value_reg;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        unique case (ctl.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                if (push) begin
                    // The cell below also gave way, so its contents move up here.
                    if (lower_push) begin
                        valid_next = lower_valid;
                        value_next = lower_value;
                    end else begin
                        valid_next = 1'b1;
                        value_next = ctl.value;
                    end
                end
            end
            CELL_SHIFT_UP: begin
                valid_next = lower_valid;
                value_next = lower_value;
            end
            CELL_SHIFT_DOWN: begin
                valid_next = upper_valid;
                value_next = upper_value;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// ===== src/isort_ctrl.sv =====
// Sequencer for the sorter: collects a set, then drains it in the chosen order.
module isort_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_last_in,
    output logic                s_ready,
    input  logic                m_ready,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                top_valid,
    output isort_pkg::cell_op_t op,
    output isort_pkg::out_ctl_t out_ctl
);
    import isort_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  overflow_reg;
    logic                  overflow_next;
    logic                  dir_reg;
    logic                  dir_next;
    logic                  asc_reg;

    always_comb begin
        state_next          = state_reg;
        count_next          = count_reg;
        overflow_next       = overflow_reg;
        dir_next            = dir_reg;
        op                  = CELL_HOLD;
        s_ready             = 1'b0;
        out_ctl.m_valid     = 1'b0;
        out_ctl.m_last      = (count_reg == COUNT_BITS'(1));
        out_ctl.m_overflow  = overflow_reg;
        out_ctl.take_bottom = dir_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (count_reg < COUNT_BITS'(MAX_ITEMS)) begin
                        op         = CELL_INSERT;
                        count_next = COUNT_BITS'(count_reg + 1'b1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (s_last_in) begin
                        state_next = ST_DRAIN;
                        dir_next   = asc_reg;
                    end
                end
            end
            ST_DRAIN: begin
                // Largest first: the set is slid up until its top reaches the last cell.
                if (dir_reg || top_valid) begin
                    out_ctl.m_valid = 1'b1;
                    if (m_ready) begin
                        op         = dir_reg ? CELL_SHIFT_DOWN : CELL_SHIFT_UP;
                        count_next = COUNT_BITS'(count_reg - 1'b1);
                        if (count_reg == COUNT_BITS'(1)) begin
                            state_next    = ST_COLLECT;
                            overflow_next = 1'b0;
                        end
                    end
                end else begin
                    op = CELL_SHIFT_UP;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_COLLECT;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            dir_reg      <= 1'b1;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            dir_reg      <= dir_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            asc_reg <= 1'b1;
        end else if (cfg_we) begin
            asc_reg <= cfg_wdata;
        end
    end

endmodule

// ===== src/insertion_sorter.sv =====
// Collecting phase: one request per cycle, each placed in the cell chain in the cycle it arrives.
// Draining, smallest first: results follow one per cycle while m_ready is high, from the cycle
// after the last request. Draining, largest first: the set slides up the chain first, until its
// top item reaches the last cell, and results are then taken from that top cell.
// Synchronous active-low reset empties every cell and sets the direction to ascending.
module insertion_sorter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  isort_pkg::value_t s_value_in,
    input  logic              s_last_in,
    output logic              m_valid,
    input  logic              m_ready,
    output isort_pkg::value_t m_value_out,
    output logic              m_last_out,
    output logic              m_overflow,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);
    import isort_pkg::*;

    cell_op_t  op;
    out_ctl_t  out_ctl;
    cell_ctl_t cell_ctl;

    logic   cell_push  [MAX_ITEMS];
    logic   cell_valid [MAX_ITEMS];
    value_t cell_value [MAX_ITEMS];
    logic   lower_push [MAX_ITEMS];
    logic   lower_valid[MAX_ITEMS];
    value_t lower_value[MAX_ITEMS];
    logic   upper_valid[MAX_ITEMS];
    value_t upper_value[MAX_ITEMS];

    isort_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_last_in (s_last_in),
        .s_ready   (s_ready),
        .m_ready   (m_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .top_valid (cell_valid[MAX_ITEMS-1]),
        .op        (op),
        .out_ctl   (out_ctl)
    );

    assign cell_ctl.op    = op;
    assign cell_ctl.value = s_value_in;

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        if (i == 0) begin : g_bottom
            assign lower_push[i]  = 1'b0;
            assign lower_valid[i] = 1'b0;
            assign lower_value[i] = '0;
        end else begin : g_link_lower
            assign lower_push[i]  = cell_push[i-1];
            assign lower_valid[i] = cell_valid[i-1];
            assign lower_value[i] = cell_value[i-1];
        end
        if (i == MAX_ITEMS - 1) begin : g_top
            assign upper_valid[i] = 1'b0;
            assign upper_value[i] = '0;
        end else begin : g_link_upper
            assign upper_valid[i] = cell_valid[i+1];
            assign upper_value[i] = cell_value[i+1];
        end

        isort_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (cell_ctl),
            .lower_push  (lower_push[i]),
            .lower_valid (lower_valid[i]),
            .lower_value (lower_value[i]),
            .upper_valid (upper_valid[i]),
            .upper_value (upper_value[i]),
            .push        (cell_push[i]),
            .valid       (cell_valid[i]),
            .value       (cell_value[i])
        );
    end

    assign m_valid     = out_ctl.m_valid;
    assign m_last_out  = out_ctl.m_last;
    assign m_overflow  = out_ctl.m_overflow;
    assign m_value_out = out_ctl.take_bottom ? cell_value[0] : cell_value[MAX_ITEMS-1];

endmodule

// ===== src/isort_checker.sv =====
// Port-level checks on the insertion sorter, bound to its top level.
`include "assert_macros.svh"

module isort_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input isort_pkg::value_t m_value_out,
    input logic              m_last_out,
    input logic              m_overflow
);
    import isort_pkg::*;

    // No new request is taken while a set is being delivered.
    `ASSERT_SAME(a_no_take_in_drain, aclk, aresetn, m_valid, !s_ready, "input ready during drain")

    // A result that waits keeps its value.
    `ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready,
                 m_valid && $stable(m_value_out), "waiting result changed")

    // After the final result the block is ready to collect again.
    `ASSERT_NEXT(a_back_to_collect, aclk, aresetn, m_valid && m_ready && m_last_out,
                 s_ready && !m_valid, "not back to collecting after final result")

    // Within a set the results follow without gaps and share one overflow flag.
    `ASSERT_NEXT(a_set_continues, aclk, aresetn, m_valid && m_ready && !m_last_out,
                 m_valid && (m_overflow == $past(m_overflow)), "set broken or flag changed")

endmodule

bind insertion_sorter isort_checker u_isort_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_value_out (m_value_out),
    .m_last_out  (m_last_out),
    .m_overflow  (m_overflow)
);

// ===== bench/insertion_sorter_test.sv =====
// Self-checking bench for the insertion sorter: random sets of requests against a predicted order.
module insertion_sorter_test;
    import isort_pkg::*;

    localparam int HOLD_OFF    = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_GOAL   = 230;

    typedef struct {
        value_t value;
        logic   last;
    } request_t;

    typedef struct {
        value_t value;
        logic   last;
        logic   overflow;
    } sorted_t;

    logic   aclk        = 1'b0;
    logic   aresetn     = 1'b0;
    logic   s_valid     = 1'b0;
    logic   s_ready;
    value_t s_value_in  = '0;
    logic   s_last_in   = 1'b0;
    logic   m_valid;
    logic   m_ready     = 1'b0;
    value_t m_value_out;
    logic   m_last_out;
    logic   m_overflow;
    logic   cfg_we      = 1'b0;
    logic   cfg_wdata   = 1'b0;

    request_t    pending_requests[$];
    sorted_t     sorted_results[$];
    value_t      held_values[$];
    logic        held_overflow = 1'b0;
    logic        sort_up       = 1'b1;
    logic        req_taken     = 1'b0;
    int          burst_left    = 8;
    int          gap_left      = 0;
    logic [15:0] ready_pattern = '1;
    int          pattern_age   = 0;
    int          idle_cycles   = 0;
    int          mismatches    = 0;
    int          requests_queued = 0;

    insertion_sorter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value_in  (s_value_in),
        .s_last_in   (s_last_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_out (m_value_out),
        .m_last_out  (m_last_out),
        .m_overflow  (m_overflow),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("Mismatch: %s", what);
    endfunction

    // Places one accepted request in the held set unless it is full, and releases the whole set in order on last.
    task automatic take_request(input value_t value, input logic last);
        int      pos;
        int      n;
        sorted_t res;
        if (held_values.size() < MAX_ITEMS) begin
            pos = held_values.size();
            while (pos > 0 && value < held_values[pos-1]) pos--;
            held_values.insert(pos, value);
        end else begin
            held_overflow = 1'b1;
        end
        if (last) begin
            n = held_values.size();
            for (int i = 0; i < n; i++) begin
                res.value    = held_values[sort_up ? i : n - 1 - i];
                res.last     = (i == n - 1);
                res.overflow = held_overflow;
                sorted_results.push_back(res);
            end
            held_values.delete();
            held_overflow = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        sorted_t want;
        if (!aresetn) begin
            held_values.delete();
            held_overflow = 1'b0;
            sort_up       = 1'b1;
        end else begin
            if (cfg_we) sort_up = cfg_wdata;
            if (s_valid && s_ready) take_request(s_value_in, s_last_in);
            if (m_valid && m_ready) begin
                if (sorted_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected result value %0d last %0b overflow %0b",
                                            m_value_out, m_last_out, m_overflow));
                end else begin
                    want = sorted_results.pop_front();
                    if (m_value_out !== want.value || m_last_out !== want.last
                            || m_overflow !== want.overflow)
                        note_mismatch($sformatf(
                            "expected value %0d last %0b overflow %0b, got %0d %0b %0b",
                            want.value, want.last, want.overflow,
                            m_value_out, m_last_out, m_overflow));
                end
            end
        end
    end

    always @(posedge aclk) req_taken <= s_valid && s_ready;

    // Request driver: bursts of random length, random gaps between them.
    always @(negedge aclk) begin
        request_t next_req;
        if (aresetn && !(s_valid && !req_taken)) begin
            if (gap_left > 0 || pending_requests.size() == 0) begin
                s_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                next_req = pending_requests.pop_front();
                s_valid    <= 1'b1;
                s_value_in <= next_req.value;
                s_last_in  <= next_req.last;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // The result side rotates a stall pattern that is replaced whenever its age counter runs out.
    always @(negedge aclk) begin
        logic [15:0] pat;
        pat = {ready_pattern[0], ready_pattern[15:1]};
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0:       pat = '1;
                1:       pat = 16'($urandom) | 16'h0001;
                2:       pat = 16'h5555;
                default: pat = 16'h8001;
            endcase
        end
        ready_pattern <= pat;
        m_ready       <= pat[0];
        pattern_age   <= (pattern_age == 0) ? 96 : pattern_age - 1;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic value_t random_value();
        case ($urandom_range(0, 4))
            0: return value_t'(int'($urandom_range(0, 6)) - 3);
            1: begin
                case ($urandom_range(0, 3))
                    0:       return {1'b0, {(VALUE_BITS-1){1'b1}}};
                    1:       return {1'b1, {(VALUE_BITS-1){1'b0}}};
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return value_t'($urandom);
        endcase
    endfunction

    task automatic add_request(input value_t value, input logic last);
        request_t req;
        req.value = value;
        req.last  = last;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    task automatic queue_set(input int n);
        for (int i = 0; i < n; i++) add_request(random_value(), i == n - 1);
    endtask

    task automatic queue_edge_sets();
        add_request({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b0);
        add_request({1'b1, {(VALUE_BITS-1){1'b0}}}, 1'b0);
        add_request('0, 1'b0);
        add_request('1, 1'b0);
        add_request(value_t'(1), 1'b0);
        add_request('1, 1'b0);
        add_request(32'sh0001_0000, 1'b0);
        add_request(32'shFFFF_0000, 1'b1);
        add_request(32'sh5555_AAAA, 1'b1);
    endtask

    // Holds the sender back until every expected result is in and the block has settled.
    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_requests.size() != 0 || s_valid || sorted_results.size() != 0);
        repeat (HOLD_OFF) @(posedge aclk);
    endtask

    task automatic set_direction(input logic up);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= up;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int sets;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_direction(1'b1);
        queue_edge_sets();
        wait_drained();
        set_direction(1'b0);
        queue_edge_sets();
        wait_drained();

        // A set past capacity, so that the request marked last is itself dropped.
        set_direction(1'b1);
        queue_set(MAX_ITEMS + 2);
        wait_drained();

        while (requests_queued < ITEM_GOAL) begin
            set_direction(1'($urandom_range(0, 1)));
            sets = $urandom_range(2, 6);
            for (int i = 0; i < sets; i++) begin
                if ($urandom_range(0, 14) == 0)
                    queue_set($urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 3));
                else
                    queue_set($urandom_range(1, 10));
            end
            wait_drained();
        end

        if (mismatches == 0 && sorted_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
